// ===== hdl/pfra_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pfra_pkg
// Shared types, constants and a helper function for the page frame
// reference count allocator.
// ---------------------------------------------------------------------------
package pfra_pkg;

    localparam int FRAME_COUNT = 4096;
    localparam int FRAME_SHIFT = 12;
    localparam int IDX_W       = $clog2(FRAME_COUNT);

    // Free flags are kept in words of FLAG_W bits, one summary bit per word.
    localparam int FLAG_W     = (FRAME_COUNT < 32) ? FRAME_COUNT : 32;
    localparam int FLAG_WORDS = FRAME_COUNT / FLAG_W;
    localparam int WIDX_W     = (FLAG_WORDS > 1) ? $clog2(FLAG_WORDS) : 1;
    localparam int BIT_W      = $clog2(FLAG_W);

    // The summary vector is searched in chunks of up to 32 bits.
    localparam int CHUNK_W = (FLAG_WORDS < 32) ? FLAG_WORDS : 32;
    localparam int CHUNKS  = FLAG_WORDS / CHUNK_W;
    localparam int CHK_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    localparam logic [7:0]  RESERVED_COUNT = 8'd100;
    localparam logic [7:0]  MAX_COUNT      = 8'd255;
    localparam logic [31:0] BASE_RESET     = 32'h0010_0000;
    localparam logic [31:0] TOP_RESET      = 32'h0100_0000;

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_START = 2'd1;
    localparam logic [1:0] REG_TOP   = 2'd2;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_BELOW     = 3'd1;
    localparam logic [2:0] STS_BEYOND    = 3'd2;
    localparam logic [2:0] STS_ALREADY   = 3'd3;
    localparam logic [2:0] STS_OOM       = 3'd4;
    localparam logic [2:0] STS_SATURATED = 3'd5;

    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_SHARE = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_A,
        S_INIT_B,
        S_INIT_C,
        S_SWEEP,
        S_SCAN,
        S_ALLOC_RD,
        S_CHECK,
        S_RMW,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] fstart;
        logic [31:0] top;
    } t_cfg;

    typedef struct packed {
        logic [31:0] address;
        logic [7:0]  count;
        logic [2:0]  status;
    } t_result;

    // Position of the highest set bit; zero when no bit is set.
    function automatic logic [4:0] top_bit(input logic [31:0] v);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/pfra_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pfra_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read.
// ---------------------------------------------------------------------------
module pfra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/pfra_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pfra_core
// Sequencer around the count memory and the free flag memory: table
// sweep, highest-free search, read-modify-write of counts, result register.
// ---------------------------------------------------------------------------
module pfra_core import pfra_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_mode   i_mode,
    input  wire logic [31:0] i_addr,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    t_state r_state, n_state;

    t_mode             r_mode, n_mode;
    logic [31:0]       r_addr, n_addr;
    logic [31:0]       r_start, n_start;
    logic [31:0]       r_first, n_first;
    logic [31:0]       r_n, n_n;
    logic [32:0]       r_last, n_last;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [FLAG_W-1:0] r_acc, n_acc;
    logic [CHK_W-1:0]  r_chunk, n_chunk;
    logic [WIDX_W-1:0] r_widx, n_widx;
    logic              r_init_op, n_init_op;
    t_result           r_pend, n_pend;
    logic [FLAG_WORDS-1:0] r_summary;
    logic              r_ovalid;
    t_result           r_res;

    logic              cnt_we;
    logic [IDX_W-1:0]  cnt_waddr, cnt_raddr;
    logic [7:0]        cnt_wdata, cnt_rdata;
    logic              flg_we;
    logic [WIDX_W-1:0] flg_waddr, flg_raddr;
    logic [FLAG_W-1:0] flg_wdata, flg_rdata;

    logic              accept;
    logic              slot_free;
    logic [31:0]       off;
    logic              below, beyond;
    logic [IDX_W-1:0]  chk_idx;
    logic [BIT_W-1:0]  bitpos;
    logic              sweep_clr;
    logic [FLAG_W-1:0] sweep_word;
    logic [CHUNK_W-1:0] chunk_v;
    logic [WIDX_W-1:0] scan_widx;
    logic [BIT_W-1:0]  abit;
    logic [IDX_W-1:0]  aidx;
    logic [FLAG_W-1:0] mod_word;
    logic [7:0]        nc;

    pfra_ram #(.WIDTH(8), .DEPTH(FRAME_COUNT)) u_counts (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    pfra_ram #(.WIDTH(FLAG_W), .DEPTH(FLAG_WORDS)) u_flags (
        .i_clk   (i_clk),
        .i_we    (flg_we),
        .i_waddr (flg_waddr),
        .i_wdata (flg_wdata),
        .i_raddr (flg_raddr),
        .o_rdata (flg_rdata)
    );

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign slot_free = !r_ovalid || i_ready;
    assign o_valid   = r_ovalid;
    assign o_res     = r_res;

    // Address checks for free and add reference.
    assign off     = r_addr - i_cfg.base;
    assign below   = r_addr < i_cfg.base;
    assign beyond  = (r_addr >= i_cfg.top) || ((off >> FRAME_SHIFT) >= 32'(FRAME_COUNT));
    assign chk_idx = IDX_W'(off >> FRAME_SHIFT);

    // Sweep: frames inside [first, last) are cleared, all others reserved.
    assign bitpos    = r_idx[BIT_W-1:0];
    assign sweep_clr = (33'(r_idx) >= {1'b0, r_first}) && (33'(r_idx) < r_last);
    always_comb begin
        sweep_word         = r_acc;
        sweep_word[bitpos] = sweep_clr;
    end

    // Highest-free search, one summary chunk per cycle from the top down.
    assign chunk_v   = r_summary[int'(r_chunk)*CHUNK_W +: CHUNK_W];
    assign scan_widx = WIDX_W'(int'(r_chunk)*CHUNK_W + int'(top_bit(32'(chunk_v))));
    assign abit      = BIT_W'(top_bit(32'(flg_rdata)));
    assign aidx      = (IDX_W'(r_widx) << BIT_W) | IDX_W'(abit);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        MODE_INIT:  n_state = S_INIT_A;
                        MODE_ALLOC: n_state = S_SCAN;
                        default:    n_state = S_CHECK;
                    endcase
                end
            end
            S_INIT_A: n_state = S_INIT_B;
            S_INIT_B: n_state = S_INIT_C;
            S_INIT_C: n_state = S_SWEEP;
            S_SWEEP: begin
                if (r_idx == IDX_W'(FRAME_COUNT - 1)) begin
                    n_state = r_init_op ? S_RESP : S_IDLE;
                end
            end
            S_SCAN: begin
                if (chunk_v != '0) begin
                    n_state = S_ALLOC_RD;
                end else if (r_chunk == '0) begin
                    n_state = S_RESP;
                end
            end
            S_ALLOC_RD: n_state = S_RESP;
            S_CHECK:    n_state = (below || beyond) ? S_RESP : S_RMW;
            S_RMW:      n_state = S_RESP;
            S_RESP: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_mode    = r_mode;
        n_addr    = r_addr;
        n_start   = r_start;
        n_first   = r_first;
        n_n       = r_n;
        n_last    = r_last;
        n_idx     = r_idx;
        n_acc     = r_acc;
        n_chunk   = r_chunk;
        n_widx    = r_widx;
        n_init_op = r_init_op;
        n_pend    = r_pend;
        cnt_we    = 1'b0;
        cnt_waddr = r_idx;
        cnt_wdata = 8'd0;
        cnt_raddr = chk_idx;
        flg_we    = 1'b0;
        flg_waddr = WIDX_W'(r_idx >> BIT_W);
        flg_wdata = sweep_word;
        flg_raddr = (r_state == S_CHECK) ? WIDX_W'(chk_idx >> BIT_W) : scan_widx;
        mod_word  = flg_rdata;
        nc        = 8'd0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode    = i_mode;
                    n_addr    = i_addr;
                    n_chunk   = CHK_W'(CHUNKS - 1);
                    n_init_op = 1'b1;
                end
            end
            S_INIT_A: begin
                n_start = (i_cfg.fstart < i_cfg.base) ? i_cfg.base : i_cfg.fstart;
            end
            S_INIT_B: begin
                n_first = (r_start - i_cfg.base) >> FRAME_SHIFT;
                n_n     = (i_cfg.top > r_start) ? ((i_cfg.top - r_start) >> FRAME_SHIFT) : 32'd0;
            end
            S_INIT_C: begin
                n_last = 33'(r_first) + 33'(r_n);
                n_idx  = '0;
            end
            S_SWEEP: begin
                cnt_we    = 1'b1;
                cnt_wdata = sweep_clr ? 8'd0 : RESERVED_COUNT;
                n_acc     = sweep_word;
                if (bitpos == BIT_W'(FLAG_W - 1)) begin
                    flg_we = 1'b1;
                end
                n_idx  = r_idx + IDX_W'(1);
                n_pend = '{address: 32'd0, count: 8'd0, status: STS_OK};
            end
            S_SCAN: begin
                if (chunk_v != '0) begin
                    n_widx = scan_widx;
                end else if (r_chunk == '0) begin
                    n_pend = '{address: 32'd0, count: 8'd0, status: STS_OOM};
                end else begin
                    n_chunk = r_chunk - CHK_W'(1);
                end
            end
            S_ALLOC_RD: begin
                cnt_we         = 1'b1;
                cnt_waddr      = aidx;
                cnt_wdata      = 8'd1;
                mod_word[abit] = 1'b0;
                flg_we         = 1'b1;
                flg_waddr      = r_widx;
                flg_wdata      = mod_word;
                n_pend = '{address: i_cfg.base + (32'(aidx) << FRAME_SHIFT),
                           count: 8'd1, status: STS_OK};
            end
            S_CHECK: begin
                if (below) begin
                    n_pend = '{address: r_addr, count: 8'd0, status: STS_BELOW};
                end else if (beyond) begin
                    n_pend = '{address: r_addr, count: 8'd0, status: STS_BEYOND};
                end else begin
                    n_idx = chk_idx;
                end
            end
            S_RMW: begin
                if (r_mode == MODE_FREE && cnt_rdata == 8'd0) begin
                    n_pend = '{address: r_addr, count: 8'd0, status: STS_ALREADY};
                end else if (r_mode != MODE_FREE && cnt_rdata == MAX_COUNT) begin
                    n_pend = '{address: r_addr, count: MAX_COUNT, status: STS_SATURATED};
                end else begin
                    nc = (r_mode == MODE_FREE) ? (cnt_rdata - 8'd1) : (cnt_rdata + 8'd1);
                    cnt_we           = 1'b1;
                    cnt_wdata        = nc;
                    mod_word[bitpos] = (nc == 8'd0);
                    flg_we           = 1'b1;
                    flg_wdata        = mod_word;
                    n_pend = '{address: r_addr, count: nc, status: STS_OK};
                end
            end
            default: begin
            end
        endcase
    end

    // After reset the sweep runs with an empty clear range, leaving every
    // frame reserved and every free flag low.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_idx     <= '0;
            r_first   <= 32'd0;
            r_last    <= 33'd0;
            r_init_op <= 1'b0;
            r_summary <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_first   <= n_first;
            r_last    <= n_last;
            r_init_op <= n_init_op;
            if (flg_we) begin
                r_summary[flg_waddr] <= |flg_wdata;
            end
            if (r_state == S_RESP && slot_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_addr  <= n_addr;
        r_start <= n_start;
        r_n     <= n_n;
        r_acc   <= n_acc;
        r_chunk <= n_chunk;
        r_widx  <= n_widx;
        r_pend  <= n_pend;
        if (r_state == S_RESP && slot_free) begin
            r_res <= r_pend;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/page_frame_refcount_allocator.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// page_frame_refcount_allocator
// Reference counted page frame allocator with an APB register port and
// stream request and result channels.
// ---------------------------------------------------------------------------
// Free and add reference: check, read, write back, result; a new request is taken
// only once the last result is registered. No write back when the address is rejected.
// Allocate: the summary chunk scan, then the flag word read and write, then the result.
// Init: a sweep with one count memory write per frame.
// Reset is synchronous; afterwards a sweep over all FRAME_COUNT (4096) frames
// marks every frame reserved before the first request is taken.
module page_frame_refcount_allocator import pfra_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // APB configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    // Request stream
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [31:0]       i_s_tdata,   // [31:0] frame_address
    input  wire logic [1:0]        i_s_tuser,   // [1:0] mode
    // Result stream
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic      [39:0]       o_m_tdata,   // [31:0] result_address, [39:32] count_after
    output logic      [2:0]        o_m_tuser    // [2:0] status
);

    t_cfg    r_cfg;
    t_result res;
    logic    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base   <= BASE_RESET;
            r_cfg.fstart <= BASE_RESET;
            r_cfg.top    <= TOP_RESET;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_BASE:  r_cfg.base   <= pwdata;
                REG_START: r_cfg.fstart <= pwdata;
                REG_TOP:   r_cfg.top    <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BASE:  prdata = r_cfg.base;
            REG_START: prdata = r_cfg.fstart;
            REG_TOP:   prdata = r_cfg.top;
            default:   prdata = 32'd0;
        endcase
    end

    pfra_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_mode  (t_mode'(i_s_tuser)),
        .i_addr  (i_s_tdata),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res)
    );

    assign o_m_tdata = {res.count, res.address};
    assign o_m_tuser = res.status;

endmodule
`default_nettype wire

// ===== bench/tb_page_frame_refcount_allocator.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_page_frame_refcount_allocator
// Self-checking bench for the page frame reference count allocator. Requests
// are driven on the input stream with random gaps. Each accepted request is
// run through a local model of the count table that predicts the result.
// Results are taken with random and long stalls and compared field by field.
// Register writes over APB are read back and move the managed window through
// its extremes.
// ---------------------------------------------------------------------------
module tb_page_frame_refcount_allocator import pfra_pkg::*; ();

    localparam int STALL_LIMIT = 40000;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr      = '0;
    logic [31:0]       pwdata     = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [31:0]       i_s_tdata  = '0;   // [31:0] frame_address
    logic [1:0]        i_s_tuser  = '0;   // [1:0] mode
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [39:0]       o_m_tdata;         // [31:0] result_address, [39:32] count_after
    logic [2:0]        o_m_tuser;         // [2:0] status

    page_frame_refcount_allocator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Local copy of the count table and the window registers.
    logic [7:0]  frame_refs [FRAME_COUNT];
    t_cfg        window_cfg;
    t_result     expected_frame_results [$];
    logic [31:0] held_frames [$];

    // Address picking is steered toward a band of frame indexes.
    logic [31:0] focus_lo   = '0;
    int          focus_span = 8;

    bit steady      = 1'b0;
    int hold_cycles = 0;
    int mismatch_count = 0;
    int requests_by_mode [4];
    int statuses_seen [8];

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void reset_frame_table();
        for (int k = 0; k < FRAME_COUNT; k++) begin
            frame_refs[k] = RESERVED_COUNT;
        end
        window_cfg.base   = BASE_RESET;
        window_cfg.fstart = BASE_RESET;
        window_cfg.top    = TOP_RESET;
    endfunction

    function automatic t_result account_frame_request(t_mode m, logic [31:0] a);
        t_result         r;
        logic [31:0]     start;
        logic [31:0]     offset;
        logic [31:0]     slot;
        longint unsigned first;
        longint unsigned span;
        logic [7:0]      c;
        bit              found;
        r = '0;
        found = 1'b0;
        case (m)
            MODE_INIT: begin
                start  = (window_cfg.fstart < window_cfg.base) ? window_cfg.base
                                                               : window_cfg.fstart;
                offset = start - window_cfg.base;
                first  = offset >> FRAME_SHIFT;
                span   = 0;
                if (window_cfg.top > start) begin
                    offset = window_cfg.top - start;
                    span   = offset >> FRAME_SHIFT;
                end
                for (int k = 0; k < FRAME_COUNT; k++) begin
                    frame_refs[k] = RESERVED_COUNT;
                end
                for (longint unsigned k = first; k < first + span && k < FRAME_COUNT; k++) begin
                    frame_refs[k] = 8'd0;
                end
                r.status = STS_OK;
            end
            MODE_ALLOC: begin
                r.status = STS_OOM;
                for (int k = FRAME_COUNT - 1; k >= 0 && !found; k--) begin
                    if (frame_refs[k] == 8'd0) begin
                        found         = 1'b1;
                        frame_refs[k] = 8'd1;
                        r.address     = window_cfg.base + (32'(k) << FRAME_SHIFT);
                        r.count       = 8'd1;
                        r.status      = STS_OK;
                    end
                end
            end
            default: begin
                r.address = a;
                offset    = a - window_cfg.base;
                slot      = offset >> FRAME_SHIFT;
                if (a < window_cfg.base) begin
                    r.status = STS_BELOW;
                end else if (a >= window_cfg.top || slot >= FRAME_COUNT) begin
                    r.status = STS_BEYOND;
                end else begin
                    c = frame_refs[slot];
                    if (m == MODE_FREE) begin
                        if (c == 8'd0) begin
                            r.status = STS_ALREADY;
                        end else begin
                            frame_refs[slot] = c - 8'd1;
                            r.count          = c - 8'd1;
                        end
                    end else if (c == MAX_COUNT) begin
                        r.count  = MAX_COUNT;
                        r.status = STS_SATURATED;
                    end else begin
                        frame_refs[slot] = c + 8'd1;
                        r.count          = c + 8'd1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] want,
                                   input logic [39:0] got);
        if (mismatch_count < 10) begin
            $display("%0t MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
        end
        mismatch_count++;
    endtask

    // Sends one request; tvalid stays high when the next one follows without a gap.
    task automatic issue_request(input t_mode m, input logic [31:0] a);
        int      gap;
        t_result r;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= a;
        i_s_tuser  <= m;
        do @(posedge i_clk); while (!o_s_tready);
        r = account_frame_request(m, a);
        expected_frame_results.push_back(r);
        requests_by_mode[m]++;
        statuses_seen[r.status]++;
        if (m == MODE_ALLOC && r.status == STS_OK) begin
            held_frames.push_back(r.address);
            if (held_frames.size() > 32) begin
                void'(held_frames.pop_front());
            end
        end
    endtask

    task automatic await_all_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_frame_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Writes a window register and reads it back. Call only while the block is idle.
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (index)
            REG_BASE:  window_cfg.base   = value;
            REG_START: window_cfg.fstart = value;
            default:   window_cfg.top    = value;
        endcase
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            report_mismatch("register read back", 40'(value), 40'(prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_mode draw_mode(int init_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < init_pct) begin
            return MODE_INIT;
        end else if (r < init_pct + 28) begin
            return MODE_ALLOC;
        end else if (r < init_pct + 62) begin
            return MODE_FREE;
        end
        return MODE_SHARE;
    endfunction

    function automatic logic [31:0] draw_address();
        logic [31:0] low;
        int          pick;
        low  = 32'($urandom_range(0, (1 << FRAME_SHIFT) - 1));
        pick = $urandom_range(0, 19);
        if (pick < 9 && held_frames.size() != 0) begin
            return held_frames[$urandom_range(0, held_frames.size() - 1)] | low;
        end else if (pick < 14) begin
            return window_cfg.base
                 + ((focus_lo + 32'($urandom_range(0, focus_span))) << FRAME_SHIFT) + low;
        end else if (pick < 17) begin
            return $urandom;
        end
        case ($urandom_range(0, 5))
            0:       return window_cfg.base - 32'd1;
            1:       return window_cfg.base;
            2:       return window_cfg.top - 32'd1;
            3:       return window_cfg.top;
            4:       return 32'd0;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic run_random_requests(input int count, input int init_pct);
        for (int n = 0; n < count; n++) begin
            issue_request(draw_mode(init_pct), draw_address());
        end
    endtask

    // Result receiver: may stall after each result, or for a long stretch on request.
    initial begin : result_sink
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        i_m_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid) begin
                stall = steady ? 0 : $urandom_range(0, 4);
            end else begin
                stall = (!steady && $urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
            end
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_frame_results.size() == 0) begin
                report_mismatch("result with no request pending", '0, o_m_tdata);
            end else begin
                want = expected_frame_results.pop_front();
                if (o_m_tdata[31:0] !== want.address) begin
                    report_mismatch("result_address", 40'(want.address),
                                    40'(o_m_tdata[31:0]));
                end
                if (o_m_tdata[39:32] !== want.count) begin
                    report_mismatch("count_after", 40'(want.count), 40'(o_m_tdata[39:32]));
                end
                if (o_m_tuser !== want.status) begin
                    report_mismatch("status", 40'(want.status), 40'(o_m_tuser));
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t watchdog: no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("page_frame_refcount_allocator regression: fail");
        $finish;
    end

    // Frames start out reserved at 100, so repeated sharing walks one up to the ceiling.
    task automatic test_refcount_saturation();
        for (int n = 0; n < 160; n++) begin
            issue_request(MODE_SHARE, 32'h0034_5000 | 32'($urandom_range(0, 4095)));
        end
        issue_request(MODE_FREE, 32'h0034_5ABC);
        issue_request(MODE_SHARE, 32'h0034_5000);
        issue_request(MODE_SHARE, 32'h0034_5FFF);
        issue_request(MODE_FREE, 32'h0034_5000);
    endtask

    task automatic test_directed_cases();
        issue_request(MODE_ALLOC, 32'h0);             // nothing free before init
        issue_request(MODE_FREE,  32'h0000_0000);
        issue_request(MODE_SHARE, 32'h000F_FFFF);     // one below the base
        issue_request(MODE_FREE,  32'h0100_0000);     // exactly at the top
        issue_request(MODE_SHARE, 32'hFFFF_FFFF);
        issue_request(MODE_FREE,  32'h0010_0000);
        issue_request(MODE_SHARE, 32'h0010_0FFF);     // offset bits are ignored
        issue_request(MODE_FREE,  32'h00FF_FFFF);
        issue_request(MODE_INIT,  32'hFFFF_FFFF);
        issue_request(MODE_ALLOC, 32'h0);
        issue_request(MODE_ALLOC, 32'hFFFF_FFFF);
        issue_request(MODE_FREE,  32'h00FF_F000);
        issue_request(MODE_FREE,  32'h00FF_F000);     // frame is already free
        issue_request(MODE_SHARE, 32'h00FF_E800);
        issue_request(MODE_SHARE, 32'h00FF_F000);     // sharing a free frame takes it
        issue_request(MODE_ALLOC, 32'h0);
        issue_request(MODE_FREE,  32'h0010_0000);
        issue_request(MODE_SHARE, 32'h0010_0000);
        issue_request(MODE_SHARE, 32'h0010_0123);
        issue_request(MODE_FREE,  32'hFFFF_F000);
        issue_request(MODE_ALLOC, 32'h5555_5555);
    endtask

    // The receiver holds off long enough for the block to back up its input.
    task automatic test_backpressure();
        focus_lo   = 32'd3828;
        focus_span = 12;
        hold_cycles = 200;
        steady = 1'b1;
        run_random_requests(24, 0);
        steady = 1'b0;
        await_all_results();
    endtask

    task automatic test_window_extremes();
        await_all_results();
        // Whole address space: the table is clipped at FRAME_COUNT frames.
        write_register(REG_BASE, 32'h0);
        write_register(REG_START, 32'h0);
        write_register(REG_TOP, 32'hFFFF_FFFF);
        focus_lo   = 32'd4088;
        focus_span = 12;
        issue_request(MODE_INIT, 32'h0);
        issue_request(MODE_ALLOC, 32'h0);
        issue_request(MODE_ALLOC, 32'h0);
        issue_request(MODE_FREE, 32'h0100_0000);
        issue_request(MODE_SHARE, 32'h00FF_FFFF);
        run_random_requests(30, 0);
        await_all_results();
        // Moving the base without a new init makes allocation addresses wrap.
        write_register(REG_BASE, 32'hFFFF_F000);
        focus_lo   = 32'd0;
        focus_span = 4;
        issue_request(MODE_ALLOC, 32'h0);
        issue_request(MODE_ALLOC, 32'h0);
        issue_request(MODE_FREE, 32'hFFFF_F000);
        issue_request(MODE_SHARE, 32'hFFFF_FFFF);
        run_random_requests(20, 0);
        await_all_results();
        // Free start below the base: init starts at the base, eight frames.
        write_register(REG_BASE, 32'h0010_0000);
        write_register(REG_START, 32'h0);
        write_register(REG_TOP, 32'h0010_8000);
        focus_span = 10;
        issue_request(MODE_INIT, 32'h0);
        run_random_requests(30, 0);
        await_all_results();
        // Top at zero: init frees nothing and every counted address at or above the base is beyond the top.
        write_register(REG_START, 32'hFFFF_F000);
        write_register(REG_TOP, 32'h0);
        issue_request(MODE_INIT, 32'h0);
        run_random_requests(20, 0);
        await_all_results();
    endtask

    // A small free pool that runs dry and refills, with pauses between rounds.
    task automatic test_small_pool();
        write_register(REG_BASE, 32'h0010_0000);
        write_register(REG_START, 32'h0014_0000);
        write_register(REG_TOP, 32'h0015_0000);
        focus_lo   = 32'd62;
        focus_span = 20;
        held_frames.delete();
        issue_request(MODE_INIT, 32'h0);
        for (int round = 0; round < 4; round++) begin
            steady = (round == 2);
            run_random_requests(100, 2);
            steady = 1'b0;
            await_all_results();
        end
        write_register(REG_BASE, BASE_RESET);
        write_register(REG_START, BASE_RESET);
        write_register(REG_TOP, TOP_RESET);
    endtask

    initial begin
        reset_frame_table();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_refcount_saturation();
        test_directed_cases();
        test_backpressure();
        test_window_extremes();
        test_small_pool();
        await_all_results();
        repeat (16) @(posedge i_clk);
        if (expected_frame_results.size() != 0) begin
            report_mismatch("results never delivered", '0, 40'(expected_frame_results.size()));
        end
        $display("Requests: %0d init, %0d allocate, %0d free, %0d share; %0d mismatches.",
                 requests_by_mode[MODE_INIT], requests_by_mode[MODE_ALLOC],
                 requests_by_mode[MODE_FREE], requests_by_mode[MODE_SHARE], mismatch_count);
        $display("Outcomes: %0d ok, %0d below base, %0d beyond top, %0d double free, %0d exhausted, %0d saturated.",
                 statuses_seen[STS_OK], statuses_seen[STS_BELOW], statuses_seen[STS_BEYOND],
                 statuses_seen[STS_ALREADY], statuses_seen[STS_OOM], statuses_seen[STS_SATURATED]);
        if (mismatch_count == 0) begin
            $display("page_frame_refcount_allocator regression: pass");
        end else begin
            $display("page_frame_refcount_allocator regression: fail");
        end
        $finish;
    end

endmodule
